FILE: rtl/core/cbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_pkg
// Types, phase codes and byte constants shared by the chunked body decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [1:0] TR_LINE_START = 2'd0;
    localparam logic [1:0] TR_START_CR   = 2'd1;
    localparam logic [1:0] TR_IN_LINE    = 2'd2;
    localparam logic [1:0] TR_LINE_CR    = 2'd3;

    typedef enum logic [8:0] {
        PH_SIZE    = 9'b000000001,
        PH_EXT     = 9'b000000010,
        PH_SIZE_LF = 9'b000000100,
        PH_DATA    = 9'b000001000,
        PH_DATA_CR = 9'b000010000,
        PH_DATA_LF = 9'b000100000,
        PH_TRAILER = 9'b001000000,
        PH_DONE    = 9'b010000000,
        PH_ERROR   = 9'b100000000
    } t_phase;

    // One result word per raw byte.
    typedef struct packed {
        logic [31:0] raw_bytes_seen;
        logic        framing_error;
        logic        body_done;
        logic        payload_valid;
        logic [7:0]  payload_byte;
    } t_result;

    // Bit 4 flags a hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            case (c) inside
                [8'h30:8'h39]: r = {1'b1, c[3:0]};
                [8'h41:8'h46],
                [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
                default:       r = 5'd0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: rtl/core/cbd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_parser
// Framing state machine: takes one raw byte per enable and produces the
// result word for it, holding size, remaining count and byte counter.
// ----------------------------------------------------------------------------
module cbd_parser #(
    parameter int SIZE_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_byte,
    output cbd_pkg::t_result o_res
);
    import cbd_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [SIZE_BITS-1:0]   r_size,  n_size;
    logic                   r_digits, n_digits;
    logic [SIZE_BITS-1:0]   r_left,  n_left;
    logic [1:0]             r_trail, n_trail;
    logic [31:0]            r_raw,   n_raw;
    logic [4:0]             hex;
    logic                   data_hit;
    logic                   taken;
    logic                   is_ext;

    localparam logic [SIZE_BITS-1:0] ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

    assign hex    = hex_digit(i_byte);
    assign is_ext = (i_byte == CH_SEMI) || (i_byte == CH_SPACE) || (i_byte == CH_TAB);

    always_comb begin
        n_phase  = r_phase;
        n_size   = r_size;
        n_digits = r_digits;
        n_left   = r_left;
        n_trail  = r_trail;
        data_hit = 1'b0;
        taken    = 1'b1;
        case (r_phase)
            PH_SIZE: begin
                if (hex[4]) begin
                    // the next digit would not fit
                    if (|r_size[SIZE_BITS-1 -: 4]) begin
                        n_phase = PH_ERROR;
                    end else begin
                        n_size   = {r_size[SIZE_BITS-5:0], hex[3:0]};
                        n_digits = 1'b1;
                    end
                end else if (i_byte == CH_CR && r_digits) begin
                    n_phase = PH_SIZE_LF;
                end else if (is_ext && r_digits) begin
                    n_phase = PH_EXT;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_EXT: begin
                if (i_byte == CH_CR) begin
                    n_phase = PH_SIZE_LF;
                end
            end
            PH_SIZE_LF: begin
                if (i_byte != CH_LF) begin
                    n_phase = PH_ERROR;
                end else if (r_size == '0) begin
                    n_phase = PH_TRAILER;
                    n_trail = TR_LINE_START;
                end else begin
                    n_left  = r_size;
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                data_hit = 1'b1;
                n_left   = r_left - ONE;
                if (r_left == ONE) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                n_phase = (i_byte == CH_CR) ? PH_DATA_LF : PH_ERROR;
            end
            PH_DATA_LF: begin
                if (i_byte == CH_LF) begin
                    n_phase  = PH_SIZE;
                    n_size   = '0;
                    n_digits = 1'b0;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_TRAILER: begin
                case (r_trail)
                    TR_LINE_START: begin
                        n_trail = (i_byte == CH_CR) ? TR_START_CR : TR_IN_LINE;
                    end
                    TR_START_CR: begin
                        n_phase = (i_byte == CH_LF) ? PH_DONE : PH_ERROR;
                    end
                    TR_IN_LINE: begin
                        if (i_byte == CH_CR) begin
                            n_trail = TR_LINE_CR;
                        end
                    end
                    default: begin
                        if (i_byte == CH_LF) begin
                            n_trail = TR_LINE_START;
                        end else begin
                            n_phase = PH_ERROR;
                        end
                    end
                endcase
            end
            default: begin
                // done or error: drop the byte
                taken = 1'b0;
            end
        endcase
        if (n_phase == PH_ERROR) begin
            taken = 1'b0;
        end
        n_raw = (taken && !(&r_raw)) ? r_raw + 32'd1 : r_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SIZE;
            r_size   <= '0;
            r_digits <= 1'b0;
            r_left   <= '0;
            r_trail  <= TR_LINE_START;
            r_raw    <= 32'd0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_size   <= n_size;
            r_digits <= n_digits;
            r_left   <= n_left;
            r_trail  <= n_trail;
            r_raw    <= n_raw;
        end
    end

    assign o_res.payload_byte   = data_hit ? i_byte : 8'd0;
    assign o_res.payload_valid  = data_hit;
    assign o_res.body_done      = (n_phase == PH_DONE);
    assign o_res.framing_error  = (n_phase == PH_ERROR);
    assign o_res.raw_bytes_seen = n_raw;

endmodule

FILE: rtl/core/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Strips chunked transfer framing from a raw body byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one raw body byte per word. m_axis returns exactly one
//   word per input byte: the payload byte (tuser high when it is chunk
//   data), done and error flags, and the saturating count of bytes taken.
//   An input register holds each accepted byte and feeds the framing state
//   machine, whose result lands in an output register that drives m_axis.
//   Throughput is one byte per cycle while m_axis_tready stays high.
//   When the receiver stalls, the output register holds its word and the
//   input register takes one more byte before s_axis_tready drops.
//   Reset (synchronous, active low) returns the parser to the start of a
//   size line, clears the byte count and empties both registers; s_axis_tready
//   stays low while reset is held.
//   Errors and the end of the body are sticky until reset; later bytes
//   still yield a word each, with the flags and count held.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] payload_byte, [8] body_done,
                                        // [9] framing_error, [41:10] raw_bytes_seen
    output logic        m_axis_tuser    // [0] payload_valid
);
    import cbd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    res;
    logic       advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_in_valid || advance);

    cbd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.raw_bytes_seen, r_out.framing_error,
                            r_out.body_done, r_out.payload_byte};
    assign m_axis_tuser  = r_out.payload_valid;

    // A loaded result is always presented.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register lost a word");

    // Done and error never appear together.
    a_done_xor_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.body_done && r_out.framing_error))
        else $error("body_done and framing_error both set");

    // The error flag stays set on the next result.
    a_bad_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.framing_error && advance) |=> r_out.framing_error)
        else $error("framing_error cleared without reset");

    // Payload words come only while the body is still open.
    a_payload_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.payload_valid) |-> (!r_out.body_done && !r_out.framing_error))
        else $error("payload reported after end or error");

endmodule
